/* rtl/core/lsf_pkg.sv */
// shared types, codes and defaults for the least-squares line fit
`default_nettype none

package lsf_pkg;

   localparam int MAX_POINTS_DEFAULT = 256;
   localparam logic signed [15:0] EVAL_X_RESET = 16'sd20992;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_TOO_FEW   = 3'd1,
      STAT_VERTICAL  = 3'd2,
      STAT_ZERO_VAR  = 3'd3,
      STAT_OVERFLOW  = 3'd4
   } status_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] slope;
      logic signed [31:0] intercept;
      logic [16:0]        r_squared;
      logic signed [31:0] fitted_y;
      logic [8:0]         point_count;
      status_type         status;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/core/lsf_req_if.sv */
// point channel: valid/ready with one point as payload
`default_nettype none

interface lsf_req_if;
   logic             valid;
   logic             ready;
   lsf_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/lsf_rsp_if.sv */
// fit result channel: valid/ready with one fit as payload
`default_nettype none

interface lsf_rsp_if;
   logic             valid;
   logic             ready;
   lsf_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/least_squares_line_fit.sv */
// least-squares line fit over a stream of points, shared multiplier and divider
//
//   channel   dir   handshake            payload
//   req_ch    in    valid/ready          x, y, last
//   rsp_ch    out   valid/ready          slope, intercept, r_squared, fitted_y,
//                                        point_count, status
//   csr       in    csr_wr_en            csr_wr_data = eval_x
//
// a point is the transfer, then x*x, x*y, y*y in turn through one 16x16 multiplier.
// a last point adds the fit: 11 products on a shift-add multiplier and up to 4 quotients
// on a restoring divider. reset is synchronous and clears the sums and the count.
// req_ch is not ready from a transfer until the point (and any fit) is done, and a
// fit holds until rsp_ch takes it.
`default_nettype none

module least_squares_line_fit #(
   parameter int MAX_POINTS = lsf_pkg::MAX_POINTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   lsf_req_if.sink          req_ch,
   lsf_rsp_if.source        rsp_ch,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int SW   = 16 + CW;
   localparam int QW   = 32 + CW;
   localparam int PW   = 2 * CW + 32;
   localparam int BW   = 2 * CW + 47;
   localparam int MW   = 2 * PW;
   localparam int NUMW = MW + 16;
   localparam int DENW = MW;
   localparam int MCW  = $clog2(PW);
   localparam int DCW  = $clog2(NUMW);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SQ    = 7'b0000010,
      S_SETUP = 7'b0000100,
      S_MUL   = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_WB    = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {SQ_XX, SQ_XY, SQ_YY} sq_phase_type;

   typedef enum logic [3:0] {
      STEP_SXX_A, STEP_SXX_B, STEP_SYY_A, STEP_SYY_B, STEP_SXY_A, STEP_SXY_B,
      STEP_BN_A, STEP_BN_B, STEP_SLOPE, STEP_ICPT, STEP_FIT_M, STEP_FIT_D,
      STEP_R2_A, STEP_R2_B, STEP_R2_D
   } step_type;

   state_type          state_ff, state_in;
   step_type           step_ff, step_in;
   sq_phase_type       phase_ff, phase_in;
   logic signed [15:0] x_ff, x_in, y_ff, y_in, eval_x_ff, eval_x_in;
   logic               last_ff, last_in, ovf_ff, ovf_in;
   logic [CW-1:0]      count_ff, count_in;
   logic signed [SW-1:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic signed [QW-1:0] sum_xx_ff, sum_xx_in, sum_xy_ff, sum_xy_in, sum_yy_ff, sum_yy_in;
   logic [MW-1:0]      ma_ff, ma_in, macc_ff, macc_in;
   logic [PW-1:0]      mb_ff, mb_in;
   logic               mneg_ff, mneg_in, dneg_ff, dneg_in;
   logic [MCW-1:0]     mcnt_ff, mcnt_in;
   logic [NUMW-1:0]    dq_ff, dq_in;
   logic [DENW-1:0]    drem_ff, drem_in, dden_ff, dden_in, dd_ff, dd_in;
   logic [DCW-1:0]     dcnt_ff, dcnt_in;
   logic signed [MW-1:0] t_ff, t_in;
   logic signed [PW-1:0] sxx_ff, sxx_in, syy_ff, syy_in, sxy_ff, sxy_in;
   logic signed [BW-1:0] bnum_ff, bnum_in;
   logic signed [31:0] slope_ff, slope_in, icpt_ff, icpt_in, fit_ff, fit_in;
   logic [16:0]        r2_ff, r2_in;
   lsf_pkg::status_type status_ff, status_in;

   logic signed [15:0] sq_a, sq_b;
   logic signed [31:0] sq_p;
   logic signed [PW-1:0] mul_a, mul_b;
   logic [PW-1:0]      mag_a, mag_b;
   logic signed [NUMW-1:0] num_sel;
   logic [DENW-1:0]    den_sel;
   logic signed [MW-1:0] prod, diff;
   logic [DENW:0]      rem_sh;
   logic               rem_ge, rnd, big, fit_go, div_step;
   logic [NUMW:0]      qr;
   logic [31:0]        sat_q;
   logic [CW+8:0]      cnt_ext;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = (state_ff == S_OUT);
   assign cnt_ext = {9'b0, count_ff};

   always_comb begin
      rsp_ch.payload.slope       = slope_ff;
      rsp_ch.payload.intercept   = icpt_ff;
      rsp_ch.payload.r_squared   = r2_ff;
      rsp_ch.payload.fitted_y    = fit_ff;
      rsp_ch.payload.point_count = cnt_ext[8:0];
      rsp_ch.payload.status      = status_ff;
   end

   // shared datapath terms
   always_comb begin
      case (phase_ff)
         SQ_XX: begin
            sq_a = x_ff;
            sq_b = x_ff;
         end
         SQ_XY: begin
            sq_a = x_ff;
            sq_b = y_ff;
         end
         default: begin
            sq_a = y_ff;
            sq_b = y_ff;
         end
      endcase
      sq_p = sq_a * sq_b;

      case (step_ff)
         STEP_SXX_A: begin
            mul_a = PW'(count_ff);
            mul_b = PW'(sum_xx_ff);
         end
         STEP_SXX_B: begin
            mul_a = PW'(sum_x_ff);
            mul_b = PW'(sum_x_ff);
         end
         STEP_SYY_A: begin
            mul_a = PW'(count_ff);
            mul_b = PW'(sum_yy_ff);
         end
         STEP_SYY_B: begin
            mul_a = PW'(sum_y_ff);
            mul_b = PW'(sum_y_ff);
         end
         STEP_SXY_A: begin
            mul_a = PW'(count_ff);
            mul_b = PW'(sum_xy_ff);
         end
         STEP_SXY_B: begin
            mul_a = PW'(sum_x_ff);
            mul_b = PW'(sum_y_ff);
         end
         STEP_BN_A: begin
            mul_a = PW'(sum_xx_ff);
            mul_b = PW'(sum_y_ff);
         end
         STEP_BN_B: begin
            mul_a = PW'(sum_x_ff);
            mul_b = PW'(sum_xy_ff);
         end
         STEP_FIT_M: begin
            mul_a = sxy_ff;
            mul_b = PW'(eval_x_ff);
         end
         STEP_R2_A: begin
            mul_a = sxy_ff;
            mul_b = sxy_ff;
         end
         default: begin
            mul_a = sxx_ff;
            mul_b = syy_ff;
         end
      endcase
      mag_a = mul_a[PW-1] ? -mul_a : mul_a;
      mag_b = mul_b[PW-1] ? -mul_b : mul_b;

      case (step_ff)
         STEP_SLOPE: begin
            num_sel  = NUMW'(sxy_ff) <<< 16;
            den_sel  = DENW'(sxx_ff);
            div_step = 1'b1;
         end
         STEP_ICPT: begin
            num_sel  = NUMW'(bnum_ff) <<< 8;
            den_sel  = DENW'(sxx_ff);
            div_step = 1'b1;
         end
         STEP_FIT_D: begin
            num_sel  = NUMW'(t_ff) <<< 8;
            den_sel  = DENW'(sxx_ff);
            div_step = 1'b1;
         end
         STEP_R2_D: begin
            num_sel  = NUMW'(t_ff) <<< 16;
            den_sel  = dd_ff;
            div_step = 1'b1;
         end
         default: begin
            num_sel  = NUMW'(t_ff);
            den_sel  = dd_ff;
            div_step = 1'b0;
         end
      endcase

      prod   = mneg_ff ? $signed(MW'(0) - macc_ff) : $signed(macc_ff);
      diff   = t_ff - prod;
      rem_sh = {drem_ff, dq_ff[NUMW-1]};
      rem_ge = (rem_sh >= {1'b0, dden_ff});
      // round half away from zero on the magnitude, then saturate
      rnd    = ({drem_ff, 1'b0} >= {1'b0, dden_ff});
      qr     = {1'b0, dq_ff} + (NUMW+1)'(rnd);
      big    = |qr[NUMW:31];
      if (dneg_ff) begin
         sat_q = big ? 32'h8000_0000 : 32'd0 - qr[31:0];
      end else begin
         sat_q = big ? 32'h7FFF_FFFF : qr[31:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      phase_in  = phase_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      last_in   = last_ff;
      eval_x_in = eval_x_ff;
      ovf_in    = ovf_ff;
      count_in  = count_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      sum_xx_in = sum_xx_ff;
      sum_xy_in = sum_xy_ff;
      sum_yy_in = sum_yy_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      macc_in   = macc_ff;
      mneg_in   = mneg_ff;
      mcnt_in   = mcnt_ff;
      dq_in     = dq_ff;
      drem_in   = drem_ff;
      dden_in   = dden_ff;
      dneg_in   = dneg_ff;
      dcnt_in   = dcnt_ff;
      dd_in     = dd_ff;
      t_in      = t_ff;
      sxx_in    = sxx_ff;
      syy_in    = syy_ff;
      sxy_in    = sxy_ff;
      bnum_in   = bnum_ff;
      slope_in  = slope_ff;
      icpt_in   = icpt_ff;
      fit_in    = fit_ff;
      r2_in     = r2_ff;
      status_in = status_ff;
      fit_go    = 1'b0;

      if (csr_wr_en) begin
         eval_x_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               x_in    = req_ch.payload.x;
               y_in    = req_ch.payload.y;
               last_in = req_ch.payload.last;
               if (count_ff < CW'(MAX_POINTS)) begin
                  count_in = count_ff + CW'(1);
                  sum_x_in = sum_x_ff + SW'(req_ch.payload.x);
                  sum_y_in = sum_y_ff + SW'(req_ch.payload.y);
                  phase_in = SQ_XX;
                  state_in = S_SQ;
               end else begin
                  // point dropped, count stays saturated
                  ovf_in = 1'b1;
                  fit_go = req_ch.payload.last;
               end
            end
         end
         S_SQ: begin
            case (phase_ff)
               SQ_XX: begin
                  sum_xx_in = sum_xx_ff + QW'(sq_p);
                  phase_in  = SQ_XY;
               end
               SQ_XY: begin
                  sum_xy_in = sum_xy_ff + QW'(sq_p);
                  phase_in  = SQ_YY;
               end
               default: begin
                  sum_yy_in = sum_yy_ff + QW'(sq_p);
                  state_in  = S_IDLE;
                  fit_go    = last_ff;
               end
            endcase
         end
         S_SETUP: begin
            if (div_step) begin
               dneg_in  = num_sel[NUMW-1];
               dq_in    = num_sel[NUMW-1] ? -num_sel : num_sel;
               drem_in  = '0;
               dden_in  = den_sel;
               dcnt_in  = '0;
               state_in = S_DIV;
            end else begin
               mneg_in  = mul_a[PW-1] ^ mul_b[PW-1];
               ma_in    = MW'(mag_a);
               mb_in    = mag_b;
               macc_in  = '0;
               mcnt_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mb_ff[0]) begin
               macc_in = macc_ff + ma_ff;
            end
            ma_in   = ma_ff << 1;
            mb_in   = mb_ff >> 1;
            mcnt_in = mcnt_ff + MCW'(1);
            if (mcnt_ff == MCW'(PW - 1)) begin
               state_in = S_WB;
            end
         end
         S_DIV: begin
            drem_in = rem_ge ? DENW'(rem_sh - {1'b0, dden_ff}) : rem_sh[DENW-1:0];
            dq_in   = {dq_ff[NUMW-2:0], rem_ge};
            dcnt_in = dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(NUMW - 1)) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            state_in = S_SETUP;
            case (step_ff)
               STEP_SXX_A: begin
                  t_in    = prod;
                  step_in = STEP_SXX_B;
               end
               STEP_SXX_B: begin
                  sxx_in  = diff[PW-1:0];
                  step_in = STEP_SYY_A;
                  // all x equal: fixed slope of one through the origin
                  if (diff[PW-1:0] == '0) begin
                     slope_in  = 32'sh0001_0000;
                     icpt_in   = '0;
                     fit_in    = {{8{eval_x_ff[15]}}, eval_x_ff, 8'b0};
                     r2_in     = '0;
                     status_in = lsf_pkg::STAT_VERTICAL;
                     state_in  = S_OUT;
                  end
               end
               STEP_SYY_A: begin
                  t_in    = prod;
                  step_in = STEP_SYY_B;
               end
               STEP_SYY_B: begin
                  syy_in  = diff[PW-1:0];
                  step_in = STEP_SXY_A;
               end
               STEP_SXY_A: begin
                  t_in    = prod;
                  step_in = STEP_SXY_B;
               end
               STEP_SXY_B: begin
                  sxy_in  = diff[PW-1:0];
                  step_in = STEP_BN_A;
               end
               STEP_BN_A: begin
                  t_in    = prod;
                  step_in = STEP_BN_B;
               end
               STEP_BN_B: begin
                  bnum_in = diff[BW-1:0];
                  step_in = STEP_SLOPE;
               end
               STEP_SLOPE: begin
                  slope_in = sat_q;
                  step_in  = STEP_ICPT;
               end
               STEP_ICPT: begin
                  icpt_in = sat_q;
                  step_in = STEP_FIT_M;
               end
               STEP_FIT_M: begin
                  t_in    = prod + MW'(bnum_ff);
                  step_in = STEP_FIT_D;
               end
               STEP_FIT_D: begin
                  fit_in  = sat_q;
                  step_in = STEP_R2_A;
                  if (syy_ff == '0) begin
                     r2_in     = '0;
                     status_in = lsf_pkg::STAT_ZERO_VAR;
                     state_in  = S_OUT;
                  end
               end
               STEP_R2_A: begin
                  t_in    = prod;
                  step_in = STEP_R2_B;
               end
               STEP_R2_B: begin
                  dd_in   = prod;
                  step_in = STEP_R2_D;
               end
               default: begin
                  r2_in     = qr[16:0];
                  status_in = ovf_ff ? lsf_pkg::STAT_OVERFLOW : lsf_pkg::STAT_OK;
                  state_in  = S_OUT;
               end
            endcase
         end
         S_OUT: begin
            if (rsp_ch.ready) begin
               count_in  = '0;
               sum_x_in  = '0;
               sum_y_in  = '0;
               sum_xx_in = '0;
               sum_xy_in = '0;
               sum_yy_in = '0;
               ovf_in    = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fit_go) begin
         if (count_ff < CW'(2)) begin
            slope_in  = '0;
            icpt_in   = '0;
            fit_in    = '0;
            r2_in     = '0;
            status_in = lsf_pkg::STAT_TOO_FEW;
            state_in  = S_OUT;
         end else begin
            step_in  = STEP_SXX_A;
            state_in = S_SETUP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         sum_xx_ff <= '0;
         sum_xy_ff <= '0;
         sum_yy_ff <= '0;
         ovf_ff    <= 1'b0;
         eval_x_ff <= lsf_pkg::EVAL_X_RESET;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         sum_xx_ff <= sum_xx_in;
         sum_xy_ff <= sum_xy_in;
         sum_yy_ff <= sum_yy_in;
         ovf_ff    <= ovf_in;
         eval_x_ff <= eval_x_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      phase_ff  <= phase_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      last_ff   <= last_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      macc_ff   <= macc_in;
      mneg_ff   <= mneg_in;
      mcnt_ff   <= mcnt_in;
      dq_ff     <= dq_in;
      drem_ff   <= drem_in;
      dden_ff   <= dden_in;
      dneg_ff   <= dneg_in;
      dcnt_ff   <= dcnt_in;
      dd_ff     <= dd_in;
      t_ff      <= t_in;
      sxx_ff    <= sxx_in;
      syy_ff    <= syy_in;
      sxy_ff    <= sxy_in;
      bnum_ff   <= bnum_in;
      slope_ff  <= slope_in;
      icpt_ff   <= icpt_in;
      fit_ff    <= fit_in;
      r2_ff     <= r2_in;
      status_ff <= status_in;
   end

endmodule

`default_nettype wire
